[hw/rtl/simulation_time_scaler_macros.svh]
// Assertion macros shared by the time scaler RTL.
// Needs nothing; included by files that check their own logic.
`ifndef SIMULATION_TIME_SCALER_MACROS_SVH
`define SIMULATION_TIME_SCALER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("time scaler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("time scaler check failed");

`endif

[hw/rtl/sts_pkg.sv]
// Types, codes and the shared divide step of the time scaler.
// Depends on nothing; imported by every module of the block.
package sts_pkg;

    localparam int WIDTH = 64;

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_TIME     = 2'd1;
    localparam logic [1:0] CMD_TIME32   = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INVALID  = 2'd1;
    localparam logic [1:0] ERR_NEGATIVE = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    localparam logic [1:0] REG_UNIT       = 2'd0;
    localparam logic [1:0] REG_PRECISION  = 2'd1;
    localparam logic [1:0] REG_RESOLUTION = 2'd2;

    typedef enum logic [1:0] {
        CTX_IDLE,
        CTX_LOAD,
        CTX_RUN
    } ctx_state_t;

    // Status of the time context as seen by the datapath.
    typedef struct packed {
        logic             ready;
        logic             valid;
        logic [WIDTH-1:0] tpu;
    } ctx_info_t;

    // One item in flight through the cell chain.
    typedef struct packed {
        logic             vld;
        logic [1:0]       cmd;
        logic [1:0]       err;
        logic             ovf;
        logic [WIDTH-1:0] a;    // remainder or product accumulator
        logic [WIDTH-1:0] b;    // dividend/quotient or remaining delay bits
        logic [WIDTH-1:0] tick;
    } sts_word_t;

    typedef struct packed {
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
    } div_pair_t;

    // One restoring division step: shift the next dividend bit into the
    // remainder, subtract the divisor when it fits, shift the quotient bit in.
    function automatic div_pair_t div_step(input logic [WIDTH-1:0] a,
                                           input logic [WIDTH-1:0] b,
                                           input logic [WIDTH-1:0] d);
        logic [WIDTH:0] sh;
        logic [WIDTH:0] diff;
        logic           ge;
        div_pair_t      r;
        sh   = {a, b[WIDTH-1]};
        diff = sh - {1'b0, d};
        ge   = (sh >= {1'b0, d});
        r.a  = ge ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
        r.b  = {b[WIDTH-2:0], ge};
        return r;
    endfunction

endpackage

[hw/rtl/sts_ctx.sv]
// Time context registers and their check, one divide step per cycle.
// Depends on sts_pkg for the divide step, state type and status struct.
module sts_ctx import sts_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [WIDTH-1:0]    wr_data,
    output ctx_info_t           info
);

    localparam logic [1:0] PH_UNIT_MOD = 2'd0;
    localparam logic [1:0] PH_PREC_MOD = 2'd1;
    localparam logic [1:0] PH_TPU      = 2'd2;
    localparam logic [5:0] LAST_STEP   = 6'(WIDTH - 1);

    ctx_state_t        state_reg, state_next;
    logic [WIDTH-1:0]  unit_reg, prec_reg, res_reg;
    logic [WIDTH-1:0]  rem_reg, quo_reg, tpu_reg;
    logic [1:0]        phase_reg;
    logic [5:0]        step_reg;
    logic              unit_ok_reg, prec_ok_reg;
    logic [WIDTH-1:0]  divisor;
    div_pair_t         stp;

    assign divisor = (phase_reg == PH_UNIT_MOD) ? prec_reg : res_reg;
    assign stp     = div_step(rem_reg, quo_reg, divisor);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTX_IDLE: state_next = CTX_IDLE;
            CTX_LOAD: state_next = CTX_RUN;
            CTX_RUN: begin
                if (step_reg == LAST_STEP && phase_reg == PH_TPU) begin
                    state_next = CTX_IDLE;
                end
            end
            default: state_next = CTX_LOAD;
        endcase
        if (wr_en) begin
            state_next = CTX_LOAD;
        end
    end

    always_comb begin
        info.ready = (state_reg == CTX_IDLE);
        info.valid = (unit_reg != '0) && (prec_reg != '0) && (res_reg != '0) &&
                     unit_ok_reg && prec_ok_reg;
        info.tpu   = tpu_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTX_LOAD;
            unit_reg  <= 64'd1000000;
            prec_reg  <= 64'd1000;
            res_reg   <= 64'd1000;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                case (wr_index)
                    REG_UNIT:       unit_reg <= wr_data;
                    REG_PRECISION:  prec_reg <= wr_data;
                    REG_RESOLUTION: res_reg  <= wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == CTX_LOAD) begin
            phase_reg <= PH_UNIT_MOD;
            step_reg  <= '0;
            rem_reg   <= '0;
            quo_reg   <= unit_reg;
        end else if (state_reg == CTX_RUN) begin
            step_reg <= step_reg + 6'd1;
            if (step_reg == LAST_STEP) begin
                rem_reg <= '0;
                case (phase_reg)
                    PH_UNIT_MOD: begin
                        unit_ok_reg <= (stp.a == '0);
                        quo_reg     <= prec_reg;
                        phase_reg   <= PH_PREC_MOD;
                    end
                    PH_PREC_MOD: begin
                        prec_ok_reg <= (stp.a == '0);
                        quo_reg     <= unit_reg;
                        phase_reg   <= PH_TPU;
                    end
                    default: begin
                        tpu_reg <= stp.b;
                    end
                endcase
            end else begin
                rem_reg <= stp.a;
                quo_reg <= stp.b;
            end
        end
    end

endmodule

[hw/rtl/sts_cell.sv]
// One cell of the arithmetic chain: a multiply or a divide step per item.
// Depends on sts_pkg for the word type and the divide step.
module sts_cell import sts_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [WIDTH-1:0] tpu,
    input  sts_word_t        in_word,
    output sts_word_t        out_word
);

    sts_word_t        word_reg, word_next;
    logic [WIDTH+1:0] sum;
    div_pair_t        stp;

    // Schedule items run a Horner multiply from the top delay bit down;
    // any carry out means the final product cannot fit.
    always_comb begin
        word_next = in_word;
        sum = {1'b0, in_word.a, 1'b0} +
              (in_word.b[WIDTH-1] ? {2'b00, tpu} : '0);
        stp = div_step(in_word.a, in_word.b, tpu);
        if (in_word.cmd == CMD_SCHEDULE) begin
            word_next.a   = sum[WIDTH-1:0];
            word_next.b   = {in_word.b[WIDTH-2:0], 1'b0};
            word_next.ovf = in_word.ovf | (sum[WIDTH+1:WIDTH] != 2'b00);
        end else begin
            word_next.a = stp.a;
            word_next.b = stp.b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.vld <= 1'b0;
        end else if (adv) begin
            word_reg <= word_next;
        end
    end

    assign out_word = word_reg;

endmodule

[hw/rtl/sts_out.sv]
// Final add and rounding of the chain result, with an output register
// and a skid entry. Depends on sts_pkg and the assertion macro header.
`include "simulation_time_scaler_macros.svh"
module sts_out import sts_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  sts_word_t        in_word,
    input  logic [WIDTH-1:0] tpu,
    output logic             adv,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [WIDTH-1:0] m_tdata,
    output logic [1:0]       m_tuser
);

    logic             out_vld_reg, skid_vld_reg;
    logic [WIDTH-1:0] out_val_reg, skid_val_reg;
    logic [1:0]       out_err_reg, skid_err_reg;
    logic [WIDTH-1:0] res_val, half, units;
    logic [1:0]       res_err;
    logic             in_vld, take;

    assign adv    = !skid_vld_reg;
    assign in_vld = in_word.vld && adv;
    assign take   = out_vld_reg && m_tready;
    assign half   = (tpu >> 1) + {{(WIDTH-1){1'b0}}, tpu[0]};
    assign units  = in_word.b + {{(WIDTH-1){1'b0}}, (in_word.a >= half)};

    always_comb begin
        res_val = '0;
        res_err = in_word.err;
        if (in_word.err == ERR_NONE) begin
            if (in_word.cmd == CMD_SCHEDULE) begin
                if (in_word.ovf || (in_word.a > ~in_word.tick)) begin
                    res_err = ERR_OVERFLOW;
                end else begin
                    res_val = in_word.tick + in_word.a;
                end
            end else if (in_word.cmd == CMD_TIME32) begin
                res_val = {32'd0, units[31:0]};
            end else begin
                res_val = units;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (take && skid_vld_reg) begin
            skid_vld_reg <= 1'b0;
        end else if (take || !out_vld_reg) begin
            out_vld_reg <= in_vld;
        end else if (in_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && skid_vld_reg) begin
            out_val_reg <= skid_val_reg;
            out_err_reg <= skid_err_reg;
        end else if (take || !out_vld_reg) begin
            out_val_reg <= res_val;
            out_err_reg <= res_err;
        end else if (in_vld) begin
            skid_val_reg <= res_val;
            skid_err_reg <= res_err;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_err_reg;

    `STS_ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_vld_reg, out_vld_reg)
    `STS_ASSERT_IMPL(a_error_zero, aclk, aresetn, out_vld_reg && (out_err_reg != ERR_NONE), out_val_reg == '0)

endmodule

[hw/rtl/simulation_time_scaler.sv]
// Top level of the simulation time scaler: context unit, cell chain and
// output stage. Depends on sts_pkg, sts_ctx, sts_cell, sts_out and macros.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tdata: present_tick, delay_value
//                                   tuser: command, delay_is_signed
//  m_       out  m_tvalid/m_tready  tdata: result_value; tuser: error_code
//  cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Every word passes a chain of 64 cells, one per bit of the 64-bit operand,
// and then the output register; one word is accepted per cycle while the
// context unit is idle and the chain does not hold. Each cell does one
// multiply or one divide step. After reset and after every configuration
// write the context unit checks the registers with one shared divide step
// per cycle; no input word is accepted meanwhile. When the output stalls, a
// skid entry catches the word in flight and then the whole chain holds.
`include "simulation_time_scaler_macros.svh"
module simulation_time_scaler import sts_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*WIDTH-1:0]  s_tdata,   // present_tick, delay_value
    input  logic [2:0]          s_tuser,   // command[1:0], delay_is_signed
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [WIDTH-1:0]    m_tdata,   // result_value
    output logic [1:0]          m_tuser,   // error_code
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [WIDTH-1:0]    cfg_data
);

    ctx_info_t  ctx;
    sts_word_t  stage [0:WIDTH];
    sts_word_t  head_word;
    logic       adv;
    logic [1:0] cmd;
    logic [WIDTH-1:0] tick, delay;

    // Configuration is always taken; a write restarts the context check.
    assign cfg_ready = 1'b1;

    sts_ctx u_ctx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .info     (ctx)
    );

    assign s_tready = ctx.ready && adv;
    assign cmd      = s_tuser[1:0];
    assign tick     = s_tdata[WIDTH-1:0];
    assign delay    = s_tdata[2*WIDTH-1:WIDTH];

    // Build the word entering the chain. Schedule words carry the delay
    // as the multiplier; time queries carry the tick as the dividend.
    always_comb begin
        head_word.vld  = s_tvalid && s_tready;
        head_word.cmd  = cmd;
        head_word.ovf  = 1'b0;
        head_word.a    = '0;
        head_word.b    = (cmd == CMD_SCHEDULE) ? delay : tick;
        head_word.tick = tick;
        if (!ctx.valid) begin
            head_word.err = ERR_INVALID;
        end else if (cmd == CMD_SCHEDULE && s_tuser[2] && delay[WIDTH-1]) begin
            head_word.err = ERR_NEGATIVE;
        end else begin
            head_word.err = ERR_NONE;
        end
    end

    assign stage[0] = head_word;

    for (genvar i = 0; i < WIDTH; i++) begin : g_cell
        sts_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .tpu      (ctx.tpu),
            .in_word  (stage[i]),
            .out_word (stage[i+1])
        );
    end

    sts_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_word  (stage[WIDTH]),
        .tpu      (ctx.tpu),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `STS_ASSERT_NEXT(a_cfg_blocks_input, aclk, aresetn, cfg_valid && cfg_ready, !s_tready)

endmodule
